// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Branch code, also the index of the dominant quaternion component (w,x,y,z).
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

endpackage

// ===== rtl/rmq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Branch choice, square root argument and the three numerators, registered.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int W  = 16,
  parameter int F  = 14,
  parameter int AW = 19,
  parameter int LW = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vld_in,
  input  logic signed [W-1:0] m [9],
  output logic                vld,
  output rmq_pkg::branch_t    branch,
  output logic [AW-2:0]       arg_mag,
  output logic signed [LW-1:0] lane [3]
);

  localparam logic signed [AW-1:0] ONE = {{(AW-1){1'b0}}, 1'b1} << F;

  logic signed [AW-1:0] e0, e4, e8, trace, arg;
  logic                 i1, i2;
  logic signed [W-1:0]  dmax;
  logic signed [LW-1:0] d21_12, d02_20, d10_01, s10_01, s20_02, s21_12;
  logic signed [LW-1:0] lane_c [3];
  rmq_pkg::branch_t     br_c;

  assign e0    = AW'(m[0]);
  assign e4    = AW'(m[4]);
  assign e8    = AW'(m[8]);
  assign trace = e0 + e4 + e8;

  assign i1   = m[4] > m[0];
  assign dmax = i1 ? m[4] : m[0];
  assign i2   = m[8] > dmax;

  assign d21_12 = LW'(m[7]) - LW'(m[5]);
  assign d02_20 = LW'(m[2]) - LW'(m[6]);
  assign d10_01 = LW'(m[3]) - LW'(m[1]);
  assign s10_01 = LW'(m[3]) + LW'(m[1]);
  assign s20_02 = LW'(m[6]) + LW'(m[2]);
  assign s21_12 = LW'(m[7]) + LW'(m[5]);

  always_comb begin
    if (trace > 0) begin
      br_c = rmq_pkg::BR_TRACE;
    end else if (i2) begin
      br_c = rmq_pkg::BR_Z;
    end else if (i1) begin
      br_c = rmq_pkg::BR_Y;
    end else begin
      br_c = rmq_pkg::BR_X;
    end
  end

  // Lanes hold the three non-dominant components in w,x,y,z order.
  always_comb begin
    unique case (br_c)
      rmq_pkg::BR_TRACE: begin
        arg = trace + ONE;
        lane_c[0] = d21_12; lane_c[1] = d02_20; lane_c[2] = d10_01;
      end
      rmq_pkg::BR_X: begin
        arg = e0 - e4 - e8 + ONE;
        lane_c[0] = d21_12; lane_c[1] = s10_01; lane_c[2] = s20_02;
      end
      rmq_pkg::BR_Y: begin
        arg = e4 - e8 - e0 + ONE;
        lane_c[0] = d02_20; lane_c[1] = s10_01; lane_c[2] = s21_12;
      end
      default: begin
        arg = e8 - e0 - e4 + ONE;
        lane_c[0] = d10_01; lane_c[1] = s20_02; lane_c[2] = s21_12;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld     <= vld_in;
      branch  <= br_c;
      arg_mag <= (arg > 0) ? arg[AW-2:0] : '0;
      lane    <= lane_c;
    end
  end

endmodule

// ===== rtl/rmq_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined floored integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int SW = 32,
  parameter int PW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [SW-1:0]        rad_in,
  input  logic [PW-1:0]        side_in,
  output logic                 vld_out,
  output logic [SW/2-1:0]      root_out,
  output logic [PW-1:0]        side_out
);

  localparam int R  = SW / 2;
  localparam int RW = R + 2;

  logic [SW-1:0] rad  [R];
  logic [RW-1:0] rem  [R];
  logic [R-1:0]  root [R];
  logic [PW-1:0] side [R];
  logic          vld  [R];

  for (genvar s = 0; s < R; s++) begin : g_stage
    logic [SW-1:0] rad_i;
    logic [RW-1:0] rem_i, rem_sh, trial;
    logic [R-1:0]  root_i;
    logic [PW-1:0] side_i;
    logic          vld_i;

    if (s == 0) begin : g_first
      assign rad_i  = rad_in;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = side_in;
      assign vld_i  = vld_in;
    end else begin : g_next
      assign rad_i  = rad[s-1];
      assign rem_i  = rem[s-1];
      assign root_i = root[s-1];
      assign side_i = side[s-1];
      assign vld_i  = vld[s-1];
    end

    assign rem_sh = {rem_i[RW-3:0], rad_i[SW-1:SW-2]};
    assign trial  = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s]  <= vld_i;
        side[s] <= side_i;
        rad[s]  <= {rad_i[SW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem[s]  <= rem_sh - trial;
          root[s] <= {root_i[R-2:0], 1'b1};
        end else begin
          rem[s]  <= rem_sh;
          root[s] <= {root_i[R-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_out  = vld[R-1];
  assign root_out = root[R-1];
  assign side_out = side[R-1];

endmodule

// ===== rtl/rmq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider, (|lane| << F) / (2 * root).
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int LW = 17,
  parameter int F  = 14,
  parameter int R  = 16,
  parameter int PW = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic signed [LW-1:0] lane_in [3],
  input  logic [R-1:0]         root_in,
  input  logic [PW-1:0]        side_in,
  output logic                 vld_out,
  output logic [LW+F-1:0]      quo_out [3],
  output logic                 neg_out [3],
  output logic [R-1:0]         root_out,
  output logic [PW-1:0]        side_out
);

  localparam int NW = LW + F;
  localparam int DW = R + 1;

  logic [NW-1:0] num  [NW][3];
  logic [DW-1:0] rem  [NW][3];
  logic [NW-1:0] quo  [NW][3];
  logic          neg  [NW][3];
  logic [R-1:0]  root [NW];
  logic [PW-1:0] side [NW];
  logic          vld  [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] num_i [3];
    logic [DW-1:0] rem_i [3];
    logic [NW-1:0] quo_i [3];
    logic          neg_i [3];
    logic [R-1:0]  root_i;
    logic [PW-1:0] side_i;
    logic          vld_i;
    logic [DW:0]   den;

    if (s == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [LW-1:0] mag;
        assign mag      = lane_in[l][LW-1] ? LW'(-lane_in[l]) : LW'(lane_in[l]);
        assign num_i[l] = {mag, {F{1'b0}}};
        assign rem_i[l] = '0;
        assign quo_i[l] = '0;
        assign neg_i[l] = lane_in[l][LW-1];
      end
      assign root_i = root_in;
      assign side_i = side_in;
      assign vld_i  = vld_in;
    end else begin : g_next
      assign num_i  = num[s-1];
      assign rem_i  = rem[s-1];
      assign quo_i  = quo[s-1];
      assign neg_i  = neg[s-1];
      assign root_i = root[s-1];
      assign side_i = side[s-1];
      assign vld_i  = vld[s-1];
    end

    assign den = {1'b0, root_i, 1'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s]  <= vld_i;
        root[s] <= root_i;
        side[s] <= side_i;
        for (int l = 0; l < 3; l++) begin
          num[s][l] <= {num_i[l][NW-2:0], 1'b0};
          neg[s][l] <= neg_i[l];
          if ({rem_i[l], num_i[l][NW-1]} >= den) begin
            rem[s][l] <= DW'({rem_i[l], num_i[l][NW-1]} - den);
            quo[s][l] <= {quo_i[l][NW-2:0], 1'b1};
          end else begin
            rem[s][l] <= {rem_i[l][DW-2:0], num_i[l][NW-1]};
            quo[s][l] <= {quo_i[l][NW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign vld_out  = vld[NW-1];
  assign quo_out  = quo[NW-1];
  assign neg_out  = neg[NW-1];
  assign root_out = root[NW-1];
  assign side_out = side[NW-1];

endmodule

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
`timescale 1ns / 1ps
// The result passes through the front register, the square root stages,
// the divider stages and the output register. Throughput: one matrix per
// cycle while the output is not stalled; the square root and the dividers
// are fully pipelined, one bit per stage.
// Reset (rst, synchronous, active high) clears every valid bit; data
// registers keep their contents.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Converts a 3x3 rotation matrix to a quaternion by the trace/dominant
// diagonal method, with a floored square root and truncating divisions.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic clk,
  input  logic rst,
  // Input tdata fields, lowest bit up: m00, m01, m02, m10, m11, m12, m20,
  // m21, m22, each DATA_WIDTH bits signed, zero filled to whole bytes.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // Output tdata fields, lowest bit up: qw, qx, qy, qz, each DATA_WIDTH bits
  // signed, zero filled to whole bytes.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  // Output tuser fields, lowest bit up: branch_taken (2), degenerate (1).
  output logic [2:0]                           m_axis_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int AW  = ((W > F + 1) ? W : F + 1) + 3;  // signed root argument
  localparam int SQW = AW - 1 + F;                     // radicand width
  localparam int SW  = SQW + (SQW % 2);
  localparam int R   = SW / 2;                         // root width
  localparam int LW  = W + 1;                          // numerator lane width
  localparam int NW  = LW + F;                         // quotient width
  localparam int XW  = (R > W) ? R : W;
  localparam int OTW = ((4*W+7)/8)*8;
  localparam int PW  = 3*LW + 2;

  // The whole pipeline moves together; it stalls only when a result is held
  // in the output register and the downstream side is not ready.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [W-1:0] m [9];
  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign m[i] = s_axis_tdata[i*W +: W];
  end

  // Stage 1: branch choice and operands.
  logic                 fr_vld;
  rmq_pkg::branch_t     fr_branch;
  logic [AW-2:0]        fr_arg;
  logic signed [LW-1:0] fr_lane [3];

  rmq_front #(.W(W), .F(F), .AW(AW), .LW(LW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (s_axis_tvalid),
    .m       (m),
    .vld     (fr_vld),
    .branch  (fr_branch),
    .arg_mag (fr_arg),
    .lane    (fr_lane)
  );

  // Square root of (argument << FRAC_BITS); the numerators ride alongside.
  logic [SW-1:0] rad;
  logic [PW-1:0] sq_side_in, sq_side;
  logic          sq_vld;
  logic [R-1:0]  sq_root;

  assign rad        = SW'({fr_arg, {F{1'b0}}});
  assign sq_side_in = {fr_branch, fr_lane[2], fr_lane[1], fr_lane[0]};

  rmq_sqrt #(.SW(SW), .PW(PW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (fr_vld),
    .rad_in   (rad),
    .side_in  (sq_side_in),
    .vld_out  (sq_vld),
    .root_out (sq_root),
    .side_out (sq_side)
  );

  // Three divisions by 2*root, truncated toward zero.
  logic signed [LW-1:0] dv_lane [3];
  logic                 dv_vld;
  logic [NW-1:0]        dv_quo [3];
  logic                 dv_neg [3];
  logic [R-1:0]         dv_root;
  logic [1:0]           dv_branch;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign dv_lane[l] = sq_side[l*LW +: LW];
  end

  rmq_div #(.LW(LW), .F(F), .R(R), .PW(2)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (sq_vld),
    .lane_in  (dv_lane),
    .root_in  (sq_root),
    .side_in  (sq_side[PW-1 -: 2]),
    .vld_out  (dv_vld),
    .quo_out  (dv_quo),
    .neg_out  (dv_neg),
    .root_out (dv_root),
    .side_out (dv_branch)
  );

  // Final stage: sign, saturation and placement of the components.
  localparam logic [NW-1:0] MAG_NEG = {{(NW-1){1'b0}}, 1'b1} << (W - 1);
  localparam logic [NW-1:0] MAG_POS = MAG_NEG - 1'b1;
  localparam logic [XW-1:0] HALF_MAX = XW'(MAG_POS);

  logic [W-1:0] lane_sat [3];
  logic [W-1:0] half_sat;
  logic [XW-1:0] half_x;
  logic [W-1:0] comp [4];
  logic         degen;

  for (genvar l = 0; l < 3; l++) begin : g_sat
    always_comb begin
      if (dv_neg[l]) begin
        lane_sat[l] = (dv_quo[l] > MAG_NEG) ? W'(MAG_NEG) : W'(-dv_quo[l]);
      end else begin
        lane_sat[l] = (dv_quo[l] > MAG_POS) ? W'(MAG_POS) : W'(dv_quo[l]);
      end
    end
  end

  assign half_x   = XW'(dv_root >> 1);
  assign half_sat = (half_x > HALF_MAX) ? W'(HALF_MAX) : W'(half_x);
  assign degen    = (dv_root == '0);

  // The dominant component takes root/2; the lanes fill the rest in order; a zero root gives all zeros.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (degen) begin
        comp[c] = '0;
      end else if (c == int'(dv_branch)) begin
        comp[c] = half_sat;
      end else if (c < int'(dv_branch)) begin
        comp[c] = lane_sat[c];
      end else begin
        comp[c] = lane_sat[c-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_vld;
      m_axis_tdata  <= OTW'({comp[3], comp[2], comp[1], comp[0]});
      m_axis_tuser  <= {degen, dv_branch};
    end
  end

endmodule
